@@ rtl/core/periodic_timer_slot_bank_top_assert.svh @@
// Assertion macros for the periodic timer slot bank.
`ifndef PERIODIC_TIMER_SLOT_BANK_TOP_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_BANK_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PTSB_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PTSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ptsb_pkg.sv @@
// Shared types, codes and constants of the periodic timer slot bank.
package ptsb_pkg;

    // Default number of timer slots
    localparam int SLOT_COUNT_DEF = 8;

    // Field widths
    localparam int HID_W  = 16;
    localparam int PER_W  = 31;
    localparam int CNT_W  = 33;
    localparam int CTX_W  = 32;
    localparam int DEC_W  = 26;          // 65535 ms * 1000 fits in 26 bits
    localparam int DVD_W  = CNT_W;       // dividend: magnitude of a non-positive counter
    localparam int DVS_W  = PER_W;       // divisor: period
    localparam int unsigned MS_TO_US = 1000;

    // Input kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_INSTALL = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // Result kinds
    localparam logic [2:0] RK_FIRE         = 3'd0;
    localparam logic [2:0] RK_TICK_DONE    = 3'd1;
    localparam logic [2:0] RK_INSTALL_OK   = 3'd2;
    localparam logic [2:0] RK_INSTALL_FULL = 3'd3;
    localparam logic [2:0] RK_REMOVE_DONE  = 3'd4;

    // One slot entry as stored in the slot memory
    typedef struct packed {
        logic [HID_W-1:0]        handler;
        logic [PER_W-1:0]        period;
        logic signed [CNT_W-1:0] counter;
        logic [CTX_W-1:0]        ctx;
    } slot_t;

    // Slot memory access strobes
    typedef struct packed {
        logic re;
        logic we;
    } mem_ctl_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // One result word
    typedef struct packed {
        logic [2:0]       result_kind;
        logic [2:0]       slot_index;
        logic [HID_W-1:0] fired_handler;
        logic [CTX_W-1:0] fired_context;
        logic [15:0]      fire_count;
        logic [3:0]       removed_count;
        logic             last;
    } res_t;

endpackage

@@ rtl/core/periodic_timer_slot_bank_top.sv @@
// Top level of the periodic timer slot bank: sequencer, slot memory and divider.
// Install: scans the slots, each read then evaluated, until a free one, then one result word.
// Remove: every slot is read and evaluated, one result word. Tick: every slot is read
// and evaluated, and each firing slot waits on the one-bit-per-cycle divider, then done.
// One input word at a time.
// Reset clears control state and all slot valid bits at once; no clearing pass.
module periodic_timer_slot_bank_top #(
    parameter int SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // elapsed_ms, handler_id, period_us, context_value
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // slot_index, fired_handler, fired_context,
                                  // fire_count, removed_count
    output logic [2:0]  m_tuser,  // result_kind
    output logic        m_tlast
);
    import ptsb_pkg::*;

    `include "periodic_timer_slot_bank_top_assert.svh"

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    mem_ctl_t         mem_ctl;
    logic [IDX_W-1:0] mem_addr;
    slot_t            mem_wdata;
    slot_t            mem_rdata;
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    div_stat_t        div_stat;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    ptsb_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_stat     (div_stat),
        .div_quo      (div_quo),
        .div_rem      (div_rem)
    );

    ptsb_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    ptsb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Checks on sequencing between the sequencer, memory and divider
    `PTSB_ASSERT_HOLD(a_mem_rw_excl, mem_ctl.re, !mem_ctl.we, "slot memory read and write overlap")
    `PTSB_ASSERT_HOLD(a_div_idle, div_start, !div_stat.busy, "divider restarted while busy")
    `PTSB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && (s_tuser != KIND_UNUSED), !s_tready, "new word taken while a word is in work")
    `PTSB_ASSERT_HOLD(a_fire_not_last, m_tvalid && (m_tuser == RK_FIRE), !m_tlast, "fire word marked last")

endmodule

@@ rtl/core/ptsb_slot_ram.sv @@
// Slot memory: one entry per timer slot, synchronous read, with per-entry valid bits.
module ptsb_slot_ram #(
    parameter int SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptsb_pkg::mem_ctl_t   ctl,
    input  logic [IDX_W-1:0]     addr,
    input  ptsb_pkg::slot_t      wdata,
    output ptsb_pkg::slot_t      rdata
);
    import ptsb_pkg::*;

    slot_t                 slot_mem [SLOT_COUNT];
    slot_t                 rd_raw_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;

    // Write and read the array; read data is registered
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            slot_mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rd_raw_reg <= slot_mem[addr];
        end
    end

    // Track which entries were written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.re)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    // Unwritten entries read as a free slot
    always_comb
    begin
        rdata = rd_raw_reg;
        if (!rd_valid_reg)
        begin
            rdata.handler = '0;
            rdata.period  = '0;
            rdata.counter = '0;
        end
    end

endmodule

@@ rtl/core/ptsb_div.sv @@
// Restoring divider, one quotient bit per cycle, for the fire count of a slot.
module ptsb_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ptsb_pkg::DVD_W-1:0]     dividend,
    input  logic [ptsb_pkg::DVS_W-1:0]     divisor,
    output ptsb_pkg::div_stat_t            stat,
    output logic [ptsb_pkg::DVD_W-1:0]     quotient,
    output logic [ptsb_pkg::DVS_W-1:0]     remainder
);
    import ptsb_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W+1:0]  diff;
    logic              fits;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        fits  = !diff[DVS_W+1];
    end

    // Load on start, then shift one quotient bit in per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DVD_W);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg  <= {quo_reg[DVD_W-2:0], fits};
            rem_reg  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/ptsb_seq.sv @@
// Sequencer: walks the slot memory for each input word and drives the result register.
module ptsb_seq #(
    parameter int SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [95:0]                s_tdata,  // elapsed_ms, handler_id, period_us, context_value
    input  logic [1:0]                 s_tuser,  // kind
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [71:0]                m_tdata,  // slot_index, fired_handler, fired_context,
                                                 // fire_count, removed_count
    output logic [2:0]                 m_tuser,  // result_kind
    output logic                       m_tlast,
    // Slot memory
    output ptsb_pkg::mem_ctl_t         mem_ctl,
    output logic [IDX_W-1:0]           mem_addr,
    output ptsb_pkg::slot_t            mem_wdata,
    input  ptsb_pkg::slot_t            mem_rdata,
    // Divider
    output logic                       div_start,
    output logic [ptsb_pkg::DVD_W-1:0] div_dividend,
    output logic [ptsb_pkg::DVS_W-1:0] div_divisor,
    input  ptsb_pkg::div_stat_t        div_stat,
    input  logic [ptsb_pkg::DVD_W-1:0] div_quo,
    input  logic [ptsb_pkg::DVS_W-1:0] div_rem
);
    import ptsb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } ptsb_state_t;

    ptsb_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       rem_cnt_reg, rem_cnt_next;
    logic             out_vld_reg;
    res_t             out_reg;
    res_t             res_next;
    logic             out_load;

    logic [1:0]       kind_reg;
    logic [DEC_W-1:0] dec_reg;
    logic [HID_W-1:0] hid_reg;
    logic [PER_W-1:0] period_reg;
    logic [CTX_W-1:0] ctx_reg;

    logic             accept;
    logic             out_free;
    logic             live;
    logic [CNT_W:0]   c_wide;
    logic [CNT_W:0]   neg_c;
    logic             c_pos;
    logic             last_slot;
    logic             match;
    logic [3:0]       rem_cnt_inc;
    logic             fire_sat;
    logic [15:0]      times;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // Per-slot arithmetic on the entry just read
    always_comb
    begin
        live        = (mem_rdata.handler != '0) && (mem_rdata.period != '0);
        c_wide      = {mem_rdata.counter[CNT_W-1], mem_rdata.counter} - (CNT_W+1)'(dec_reg);
        c_pos       = !c_wide[CNT_W] && (c_wide != '0);
        neg_c       = (CNT_W+1)'(0) - c_wide;
        last_slot   = (idx_reg == IDX_W'(SLOT_COUNT - 1));
        match       = (hid_reg != '0) && (mem_rdata.handler == hid_reg);
        rem_cnt_inc = (rem_cnt_reg == 4'hF) ? rem_cnt_reg : rem_cnt_reg + 4'd1;
        fire_sat    = (|div_quo[DVD_W-1:16]) || (div_quo[15:0] == 16'hFFFF);
        times       = fire_sat ? 16'hFFFF : div_quo[15:0] + 16'd1;
    end

    // Sequence one input word over the slots
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rem_cnt_next = rem_cnt_reg;
        mem_ctl      = '0;
        mem_wdata    = mem_rdata;
        out_load     = 1'b0;
        res_next     = '0;
        div_start    = 1'b0;
        div_dividend = neg_c[DVD_W-1:0];
        div_divisor  = mem_rdata.period;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser != KIND_UNUSED))
                begin
                    state_next   = ST_RD;
                    idx_next     = '0;
                    rem_cnt_next = '0;
                end
            end

            ST_RD:
            begin
                mem_ctl.re = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                case (kind_reg)
                    KIND_TICK:
                    begin
                        if (live && !c_pos)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            // Still positive: store the reduced counter
                            if (live)
                            begin
                                mem_ctl.we        = 1'b1;
                                mem_wdata.counter = c_wide[CNT_W-1:0];
                            end
                            if (last_slot)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = ST_RD;
                            end
                        end
                    end

                    KIND_INSTALL:
                    begin
                        if (mem_rdata.handler == '0)
                        begin
                            if (out_free)
                            begin
                                mem_ctl.we           = 1'b1;
                                mem_wdata.handler    = hid_reg;
                                mem_wdata.period     = period_reg;
                                mem_wdata.counter    = {2'b00, period_reg};
                                mem_wdata.ctx        = ctx_reg;
                                out_load             = 1'b1;
                                res_next.result_kind = RK_INSTALL_OK;
                                res_next.slot_index  = 3'(idx_reg);
                                res_next.last        = 1'b1;
                                state_next           = ST_IDLE;
                            end
                        end
                        else if (last_slot)
                        begin
                            if (out_free)
                            begin
                                out_load             = 1'b1;
                                res_next.result_kind = RK_INSTALL_FULL;
                                res_next.last        = 1'b1;
                                state_next           = ST_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_RD;
                        end
                    end

                    KIND_REMOVE:
                    begin
                        if (last_slot)
                        begin
                            if (out_free)
                            begin
                                if (match)
                                begin
                                    mem_ctl.we = 1'b1;
                                    mem_wdata  = '0;
                                end
                                out_load               = 1'b1;
                                res_next.result_kind   = RK_REMOVE_DONE;
                                res_next.removed_count = match ? rem_cnt_inc : rem_cnt_reg;
                                res_next.last          = 1'b1;
                                state_next             = ST_IDLE;
                            end
                        end
                        else
                        begin
                            if (match)
                            begin
                                mem_ctl.we   = 1'b1;
                                mem_wdata    = '0;
                                rem_cnt_next = rem_cnt_inc;
                            end
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_RD;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_DIV:
            begin
                // Counter becomes period minus remainder; report the fire count
                if (div_stat.done && out_free)
                begin
                    mem_ctl.we             = 1'b1;
                    mem_wdata.counter      = {2'b00, mem_rdata.period - div_rem};
                    out_load               = 1'b1;
                    res_next.result_kind   = RK_FIRE;
                    res_next.slot_index    = 3'(idx_reg);
                    res_next.fired_handler = mem_rdata.handler;
                    res_next.fired_context = mem_rdata.ctx;
                    res_next.fire_count    = times;
                    if (last_slot)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    res_next.result_kind = RK_TICK_DONE;
                    res_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_addr = idx_reg;

    // Control registers and result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rem_cnt_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rem_cnt_reg <= rem_cnt_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Capture the input word and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            dec_reg    <= DEC_W'(32'(s_tdata[15:0]) * MS_TO_US);
            hid_reg    <= s_tdata[31:16];
            period_reg <= s_tdata[62:32];
            ctx_reg    <= s_tdata[94:63];
        end
        if (out_load)
        begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_reg.removed_count, out_reg.fire_count,
                       out_reg.fired_context, out_reg.fired_handler, out_reg.slot_index};
    assign m_tuser  = out_reg.result_kind;
    assign m_tlast  = out_reg.last;

endmodule
